// File: hdl/kis_pkg.sv
// package with constants, codes and shared types of the knot interval search
package kis_pkg;

  localparam int unsigned MAX_KNOTS  = 1024;
  localparam int unsigned COORD_BITS = 32;
  localparam int unsigned IDX_W      = $clog2(MAX_KNOTS);
  localparam int unsigned CNT_W      = IDX_W + 1;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = CNT_W;
  localparam int unsigned CTR_W      = 32;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_FIND  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_KNOT_COUNT   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_CACHE_ENABLE = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLO,
    S_CHI,
    S_SEARCH,
    S_DONE
  } srch_state_e;

  typedef struct packed {
    logic             start;
    logic             cache_en;
    logic [IDX_W-1:0] c_start;
    logic [IDX_W-1:0] nm1;
  } srch_req_t;

  typedef struct packed {
    logic             idle;
    logic             done;
    logic             cached;
    logic             hit;
    logic [IDX_W-1:0] idx;
  } srch_stat_t;

endpackage

// File: hdl/kis_if.sv
// request, result and configuration channel interfaces
interface kis_req_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 func;
  logic [kis_pkg::IDX_W-1:0]            knot_slot;
  logic signed [kis_pkg::COORD_BITS-1:0] coord;

  modport source (output valid, func, knot_slot, coord, input ready);
  modport sink   (input valid, func, knot_slot, coord, output ready);
endinterface

interface kis_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [kis_pkg::IDX_W-1:0]       interval_index;
  logic                            cache_hit;
  logic [kis_pkg::CTR_W-1:0]       hits_so_far;
  logic [kis_pkg::CTR_W-1:0]       misses_so_far;

  modport source (output valid, interval_index, cache_hit, hits_so_far, misses_so_far,
                  input ready);
  modport sink   (input valid, interval_index, cache_hit, hits_so_far, misses_so_far,
                  output ready);
endinterface

interface kis_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [kis_pkg::CFG_IDX_W-1:0]      index;
  logic [kis_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: hdl/kis_ram.sv
// generic single-port ram with registered read
module kis_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/kis_search.sv
// search sequencer: optional cached interval check then binary search, one probe per cycle
module kis_search (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  kis_pkg::srch_req_t                    req_i,
  input  logic signed [kis_pkg::COORD_BITS-1:0] query_i,
  input  logic signed [kis_pkg::COORD_BITS-1:0] rdata_i,
  input  logic                                  ack_i,
  output logic [kis_pkg::IDX_W-1:0]             rd_addr_o,
  output kis_pkg::srch_stat_t                   stat_o
);

  kis_pkg::srch_state_e state_q, state_d;

  logic signed [kis_pkg::COORD_BITS-1:0] query_q;
  logic [kis_pkg::IDX_W-1:0] lo_q, hi_q, mid_q, c_q, nm1_q, idx_q;
  logic [kis_pkg::IDX_W-1:0] lo_d, hi_d, mid_d, c_d, nm1_d, idx_d;
  logic cached_q, cached_d, hit_q, hit_d;

  // shared compare unit: probed knot above query
  logic gt;
  logic [kis_pkg::IDX_W-1:0] nlo, nhi, nmid;
  logic [kis_pkg::IDX_W:0]   sum;
  logic                      cont;

  assign gt = rdata_i > query_q;

  // bounds for the next probe
  always_comb begin
    case (state_q)
      kis_pkg::S_IDLE: begin
        nlo = '0;
        nhi = req_i.nm1;
      end
      kis_pkg::S_CLO: begin
        nlo = '0;
        nhi = c_q;
      end
      kis_pkg::S_CHI: begin
        nlo = c_q;
        nhi = nm1_q;
      end
      kis_pkg::S_SEARCH: begin
        nlo = gt ? lo_q : mid_q;
        nhi = gt ? mid_q : hi_q;
      end
      default: begin
        nlo = lo_q;
        nhi = hi_q;
      end
    endcase
  end

  assign sum  = {1'b0, nlo} + {1'b0, nhi};
  assign nmid = sum[kis_pkg::IDX_W:1];
  assign cont = {1'b0, nhi} > ({1'b0, nlo} + {{kis_pkg::IDX_W{1'b0}}, 1'b1});

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      kis_pkg::S_IDLE: begin
        if (req_i.start) begin
          if (req_i.cache_en) begin
            state_d = kis_pkg::S_CLO;
          end else begin
            state_d = cont ? kis_pkg::S_SEARCH : kis_pkg::S_DONE;
          end
        end
      end
      kis_pkg::S_CLO: begin
        if (gt) begin
          state_d = cont ? kis_pkg::S_SEARCH : kis_pkg::S_DONE;
        end else begin
          state_d = kis_pkg::S_CHI;
        end
      end
      kis_pkg::S_CHI: begin
        if (!gt) begin
          state_d = cont ? kis_pkg::S_SEARCH : kis_pkg::S_DONE;
        end else begin
          state_d = kis_pkg::S_DONE;
        end
      end
      kis_pkg::S_SEARCH: begin
        state_d = cont ? kis_pkg::S_SEARCH : kis_pkg::S_DONE;
      end
      kis_pkg::S_DONE: begin
        if (ack_i) begin
          state_d = kis_pkg::S_IDLE;
        end
      end
      default: state_d = kis_pkg::S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    lo_d      = lo_q;
    hi_d      = hi_q;
    mid_d     = mid_q;
    c_d       = c_q;
    nm1_d     = nm1_q;
    idx_d     = idx_q;
    cached_d  = cached_q;
    hit_d     = hit_q;
    rd_addr_o = nmid;
    case (state_q)
      kis_pkg::S_IDLE: begin
        if (req_i.cache_en) begin
          rd_addr_o = req_i.c_start;
        end
        if (req_i.start) begin
          c_d      = req_i.c_start;
          nm1_d    = req_i.nm1;
          cached_d = req_i.cache_en;
          hit_d    = 1'b0;
        end
      end
      kis_pkg::S_CLO: begin
        // below the cached interval the first search probe goes out at once
        rd_addr_o = gt ? nmid : c_q + {{(kis_pkg::IDX_W-1){1'b0}}, 1'b1};
      end
      kis_pkg::S_CHI: begin
        if (gt) begin
          hit_d = 1'b1;
          idx_d = c_q;
        end
      end
      kis_pkg::S_DONE: begin
        rd_addr_o = mid_q;
      end
      default: begin
        rd_addr_o = nmid;
      end
    endcase
    if (state_d == kis_pkg::S_SEARCH) begin
      lo_d  = nlo;
      hi_d  = nhi;
      mid_d = nmid;
    end
    // search finished on its own bounds (not a cache hit)
    if (state_d == kis_pkg::S_DONE && state_q != kis_pkg::S_DONE && !hit_d) begin
      idx_d = nlo;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= kis_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start && state_q == kis_pkg::S_IDLE) begin
      query_q <= query_i;
    end
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    mid_q    <= mid_d;
    c_q      <= c_d;
    nm1_q    <= nm1_d;
    idx_q    <= idx_d;
    cached_q <= cached_d;
    hit_q    <= hit_d;
  end

  assign stat_o.idle   = (state_q == kis_pkg::S_IDLE);
  assign stat_o.done   = (state_q == kis_pkg::S_DONE);
  assign stat_o.cached = cached_q;
  assign stat_o.hit    = hit_q;
  assign stat_o.idx    = idx_q;

endmodule

// File: hdl/knot_interval_search_cached.sv
// top level of the cached knot interval search
// Knots are loaded by write requests (no result) into a
// 1024-entry table held in a single-port ram with registered read. A find
// request returns the lower knot index of the interval holding the query,
// clamped to 0 and count-2 at the ends. The single ram port sets the pace:
// one knot is read and compared per cycle while a search runs. With the cache
// enabled, one or two cache probes come ahead of the search, and on a hit no
// search follows. Requests are taken one at a time; a write or the next find
// may be accepted while a result waits in the output register. Any knot write
// clears the cached interval and both counters.
module knot_interval_search_cached (
  input  logic  clk_i,
  input  logic  rst_ni,
  kis_req_if.sink   req_i,
  kis_rsp_if.source rsp_o,
  kis_cfg_if.sink   cfg_i
);

  logic [kis_pkg::CNT_W-1:0] knot_count_q;
  logic                      cache_en_q;
  logic [kis_pkg::IDX_W-1:0] cached_q, cached_d;
  logic [kis_pkg::CTR_W-1:0] hit_q, hit_d, miss_q, miss_d;

  logic req_fire, wr_fire, find_fire, load;
  logic [kis_pkg::IDX_W-1:0] nm1, nm2, c_start, rd_addr, ram_addr;
  logic signed [kis_pkg::COORD_BITS-1:0] rdata;

  kis_pkg::srch_req_t  srch_req;
  kis_pkg::srch_stat_t srch_stat;

  logic                      out_valid_q, out_valid_d;
  logic [kis_pkg::IDX_W-1:0] out_idx_q;
  logic                      out_hit_q;
  logic [kis_pkg::CTR_W-1:0] out_hits_q, out_misses_q;

  assign req_i.ready = srch_stat.idle;
  assign req_fire    = req_i.valid && req_i.ready;
  assign wr_fire     = req_fire && (req_i.func == kis_pkg::FUNC_WRITE);
  assign find_fire   = req_fire && (req_i.func == kis_pkg::FUNC_FIND);

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      knot_count_q <= kis_pkg::CNT_W'(2);
      cache_en_q   <= 1'b0;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_i.index)
        kis_pkg::REG_KNOT_COUNT:   knot_count_q <= cfg_i.data[kis_pkg::CNT_W-1:0];
        kis_pkg::REG_CACHE_ENABLE: cache_en_q   <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  // last usable knot index, with the count saturated into range
  always_comb begin
    if (knot_count_q < kis_pkg::CNT_W'(2)) begin
      nm1 = kis_pkg::IDX_W'(1);
    end else if (knot_count_q > kis_pkg::CNT_W'(kis_pkg::MAX_KNOTS)) begin
      nm1 = kis_pkg::IDX_W'(kis_pkg::MAX_KNOTS - 1);
    end else begin
      nm1 = kis_pkg::IDX_W'(knot_count_q - kis_pkg::CNT_W'(1));
    end
    nm2     = nm1 - kis_pkg::IDX_W'(1);
    c_start = (cached_q > nm2) ? nm2 : cached_q;
  end

  assign srch_req.start    = find_fire;
  assign srch_req.cache_en = cache_en_q;
  assign srch_req.c_start  = c_start;
  assign srch_req.nm1      = nm1;

  assign ram_addr = wr_fire ? req_i.knot_slot : rd_addr;

  kis_ram #(
    .WIDTH (kis_pkg::COORD_BITS),
    .DEPTH (kis_pkg::MAX_KNOTS)
  ) u_knots (
    .clk_i   (clk_i),
    .we_i    (wr_fire),
    .addr_i  (ram_addr),
    .wdata_i (req_i.coord),
    .rdata_o (rdata)
  );

  kis_search u_search (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (srch_req),
    .query_i   (req_i.coord),
    .rdata_i   (rdata),
    .ack_i     (load),
    .rd_addr_o (rd_addr),
    .stat_o    (srch_stat)
  );

  // result moves into the output register once it is free
  assign load = srch_stat.done && (!out_valid_q || rsp_o.ready);

  always_comb begin
    cached_d = cached_q;
    hit_d    = hit_q;
    miss_d   = miss_q;
    if (wr_fire) begin
      cached_d = '0;
      hit_d    = '0;
      miss_d   = '0;
    end else if (load && srch_stat.cached) begin
      cached_d = srch_stat.idx;
      if (srch_stat.hit) begin
        hit_d = hit_q + kis_pkg::CTR_W'(1);
      end else begin
        miss_d = miss_q + kis_pkg::CTR_W'(1);
      end
    end
    out_valid_d = load ? 1'b1 : (rsp_o.ready ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cached_q    <= '0;
      hit_q       <= '0;
      miss_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cached_q    <= cached_d;
      hit_q       <= hit_d;
      miss_q      <= miss_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_idx_q    <= srch_stat.idx;
      out_hit_q    <= srch_stat.hit;
      out_hits_q   <= hit_d;
      out_misses_q <= miss_d;
    end
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.interval_index = out_idx_q;
  assign rsp_o.cache_hit      = out_hit_q;
  assign rsp_o.hits_so_far    = out_hits_q;
  assign rsp_o.misses_so_far  = out_misses_q;

`ifndef SYNTHESIS
  a_find_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    find_fire |=> !srch_stat.idle)
    else $error("find request did not start the search");

  a_write_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_fire |=> (hit_q == '0) && (miss_q == '0) && (cached_q == '0))
    else $error("knot write did not clear cache state");

  a_cached_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cached_q <= kis_pkg::IDX_W'(kis_pkg::MAX_KNOTS - 2))
    else $error("cached interval out of range");

  a_hit_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !wr_fire |=> (hit_q == $past(hit_q)) || (hit_q == $past(hit_q) + kis_pkg::CTR_W'(1)))
    else $error("hit counter jumped");
`endif

endmodule
